[sv/rtdc_pkg.sv]
// ----------------------------------------------------------------------------
// Rank table package
// Shared constants and codes for the rank table with duplicate check.
// ----------------------------------------------------------------------------
`default_nettype none

package rtdc_pkg;

    localparam int RTDC_CAPACITY = 256;

    // Command codes carried on the input side band.
    localparam logic [1:0] FN_INSERT = 2'd0;
    localparam logic [1:0] FN_READ   = 2'd1;
    localparam logic [1:0] FN_CLEAR  = 2'd2;

    // Status codes carried on the output side band.
    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_DUP    = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_NOREAD = 2'd3;

    localparam int VALUE_W = 32;
    localparam int RANK_W  = 9;
    localparam int INDEX_W = 8;

endpackage

`default_nettype wire

[sv/rank_table_with_duplicate_check_core.sv]
// ----------------------------------------------------------------------------
// Rank table with duplicate check
// Keeps up to CAPACITY distinct signed values in a memory. The rank of an
// entry is one plus the number of smaller stored values, found by a scan.
//
// Input stream: tuser carries the command (insert, read, clear); tdata
// carries the value to insert and the index to read. One word is taken only
// while the sequencer is idle. Output stream: one word per input word, with
// the status on tuser and new rank, read value and read rank on tdata.
//
// An insert scans every stored entry before its result reaches the output
// register, because one shared comparator looks at one entry per cycle
// through the memory read port. A read first fetches the indexed value and
// then scans. A clear, an unused command or an index beyond the filled
// entries answers without a scan. The next word can be taken in the cycle
// after the result enters the output register.
//
// Reset empties the table at once; no clearing pass is needed. A result
// waits in the output register while the receiver stalls, and the next
// word is still accepted; a second result waits in the sequencer until the
// output register is free, and no word is taken meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module rank_table_with_duplicate_check_core
    import rtdc_pkg::*;
#(
    parameter int CAPACITY = RTDC_CAPACITY
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // Input stream.
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [39:0] i_s_tdata,   // [31:0] new_value, [39:32] read_index
    input  wire  [1:0]  i_s_tuser,   // [1:0] func
    // Output stream.
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [55:0] o_m_tdata,   // [8:0] new_rank, [40:9] read_value,
                                     // [49:41] read_rank, [55:50] zero
    output logic [1:0]  o_m_tuser    // [1:0] status
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = (CW > INDEX_W) ? CW : INDEX_W;
    localparam int RW = (CW > RANK_W) ? CW : RANK_W;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_FETCH = 2'd1;
    localparam logic [1:0] S_SCAN  = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [VALUE_W-1:0] r_mem [CAPACITY];
    logic [VALUE_W-1:0] r_rd_data;

    logic [1:0]                r_state,      n_state;
    logic [1:0]                r_func,       n_func;
    logic signed [VALUE_W-1:0] r_key,        n_key;
    logic [CW-1:0]             r_count,      n_count;
    logic [CW-1:0]             r_scan_idx,   n_scan_idx;
    logic                      r_data_vld,   n_data_vld;
    logic [1:0]                r_res_status, n_res_status;
    logic [RANK_W-1:0]         r_res_nrank,  n_res_nrank;
    logic [VALUE_W-1:0]        r_res_value,  n_res_value;
    logic [RANK_W-1:0]         r_res_rank,   n_res_rank;

    logic                      r_out_valid;
    logic [1:0]                r_out_status;
    logic [RANK_W-1:0]         r_out_nrank;
    logic [VALUE_W-1:0]        r_out_value;
    logic [RANK_W-1:0]         r_out_rank;

    logic [AW-1:0]             w_rd_addr;
    logic                      w_wr_en;
    logic                      w_scan_start;
    logic                      w_out_free;
    logic                      w_out_load;
    logic [CW-1:0]             w_smaller;
    logic                      w_dup;
    logic [RW-1:0]             w_rank;
    logic [IW-1:0]             w_idx_ext;

    rtdc_scan_unit #(
        .CAPACITY (CAPACITY)
    ) u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_scan_start),
        .i_en      (r_data_vld),
        .i_key     (r_key),
        .i_entry   ($signed(r_rd_data)),
        .o_smaller (w_smaller),
        .o_dup     (w_dup)
    );

    assign w_rank     = RW'(w_smaller) + RW'(1);
    assign w_idx_ext  = IW'(i_s_tdata[39:32]);
    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_out_load = (r_state == S_DONE) && w_out_free;
    assign o_s_tready = (r_state == S_IDLE);

    always_comb begin
        n_state      = r_state;
        n_func       = r_func;
        n_key        = r_key;
        n_count      = r_count;
        n_scan_idx   = r_scan_idx;
        n_data_vld   = 1'b0;
        n_res_status = r_res_status;
        n_res_nrank  = r_res_nrank;
        n_res_value  = r_res_value;
        n_res_rank   = r_res_rank;
        w_rd_addr    = r_scan_idx[AW-1:0];
        w_wr_en      = 1'b0;
        w_scan_start = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_func       = i_s_tuser;
                    n_key        = $signed(i_s_tdata[31:0]);
                    n_res_status = ST_DONE;
                    n_res_nrank  = '0;
                    n_res_value  = '0;
                    n_res_rank   = '0;
                    case (i_s_tuser)
                        FN_INSERT: begin
                            w_scan_start = 1'b1;
                            n_scan_idx   = '0;
                            n_state      = S_SCAN;
                        end
                        FN_READ: begin
                            if (w_idx_ext < IW'(r_count)) begin
                                w_rd_addr = AW'(i_s_tdata[39:32]);
                                n_state   = S_FETCH;
                            end else begin
                                n_res_status = ST_NOREAD;
                                n_state      = S_DONE;
                            end
                        end
                        FN_CLEAR: begin
                            n_count = '0;
                            n_state = S_DONE;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_FETCH: begin
                // The indexed value becomes the key; its rank comes from the scan.
                n_key        = $signed(r_rd_data);
                w_scan_start = 1'b1;
                n_scan_idx   = '0;
                n_state      = S_SCAN;
            end
            S_SCAN: begin
                if (r_scan_idx < r_count) begin
                    n_scan_idx = r_scan_idx + CW'(1);
                    n_data_vld = 1'b1;
                end else if (!r_data_vld) begin
                    // The last compare has been absorbed by the scan unit.
                    n_state = S_DONE;
                    if (r_func == FN_INSERT) begin
                        if (w_dup) begin
                            n_res_status = ST_DUP;
                        end else if (r_count == CW'(CAPACITY)) begin
                            n_res_status = ST_FULL;
                        end else begin
                            w_wr_en     = 1'b1;
                            n_count     = r_count + CW'(1);
                            n_res_nrank = w_rank[RANK_W-1:0];
                        end
                    end else begin
                        n_res_value = r_key;
                        n_res_rank  = w_rank[RANK_W-1:0];
                    end
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_count[AW-1:0]] <= r_key;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_scan_idx <= '0;
            r_data_vld <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_scan_idx <= n_scan_idx;
            r_data_vld <= n_data_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func       <= n_func;
        r_key        <= n_key;
        r_res_status <= n_res_status;
        r_res_nrank  <= n_res_nrank;
        r_res_value  <= n_res_value;
        r_res_rank   <= n_res_rank;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_status <= r_res_status;
            r_out_nrank  <= r_res_nrank;
            r_out_value  <= r_res_value;
            r_out_rank   <= r_res_rank;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_status;
    assign o_m_tdata  = {6'b0, r_out_rank, r_out_value, r_out_nrank};

    // The table never holds more entries than it has room for.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count exceeds capacity");

    // A store into the memory only happens while the table has a free slot.
    a_write_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |-> (r_count < CW'(CAPACITY)))
        else $error("write into a full table");

    // Every store grows the table by exactly one entry.
    a_write_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |=> (r_count == $past(r_count) + CW'(1)))
        else $error("entry count did not follow the store");

    // A full report is only given when the table really is full.
    a_full_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_load && (r_res_status == ST_FULL)) |-> (r_count == CW'(CAPACITY)))
        else $error("full status with free slots");

    // The compare pipeline only carries data while a scan is running.
    a_scan_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_data_vld |-> (r_state == S_SCAN))
        else $error("compare data outside a scan");

endmodule

`default_nettype wire

[sv/rtdc_scan_unit.sv]
// ----------------------------------------------------------------------------
// Rank table scan unit
// Shared signed comparator with an accumulator: counts stored entries below
// the key and flags an entry equal to it, one entry per enabled cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rtdc_scan_unit
    import rtdc_pkg::*;
#(
    parameter int CAPACITY = RTDC_CAPACITY
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_start,
    input  wire                              i_en,
    input  wire  logic signed [VALUE_W-1:0]  i_key,
    input  wire  logic signed [VALUE_W-1:0]  i_entry,
    output logic [$clog2(CAPACITY+1)-1:0]    o_smaller,
    output logic                             o_dup
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic [CW-1:0] r_smaller;
    logic          r_dup;
    logic          w_less;
    logic          w_equal;

    assign w_less  = (i_entry < i_key);
    assign w_equal = (i_entry == i_key);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smaller <= '0;
            r_dup     <= 1'b0;
        end else if (i_start) begin
            r_smaller <= '0;
            r_dup     <= 1'b0;
        end else if (i_en) begin
            if (w_less) begin
                r_smaller <= r_smaller + CW'(1);
            end
            if (w_equal) begin
                r_dup <= 1'b1;
            end
        end
    end

    assign o_smaller = r_smaller;
    assign o_dup     = r_dup;

endmodule

`default_nettype wire

[sim/tb_rank_table_with_duplicate_check_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the rank table with duplicate check
// Drives insert, read, clear and unused command words into the core and
// checks every output word against a behavioral rank table kept in the
// bench. A short table of directed words comes first. Random traffic
// follows in three idling patterns. The last pattern fills the table to
// capacity and then keeps inserting, so that full and duplicate answers
// are exercised on a full table.
// ----------------------------------------------------------------------------

module tb_rank_table_with_duplicate_check_core;
    import rtdc_pkg::*;

    localparam logic [1:0] FN_UNUSED = 2'd3;
    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam int LONG_STALL_CYCLES = 400;
    localparam int DRAIN_CYCLES      = 300;
    localparam int CYCLE_LIMIT       = 1_000_000;
    localparam int MAX_REPORTS       = 50;

    typedef struct packed {
        logic [1:0]  status;
        logic [8:0]  new_rank;
        logic [31:0] read_value;
        logic [8:0]  read_rank;
    } t_rank_result;

    typedef struct packed {
        logic [1:0]   fn;
        logic [31:0]  val;
        logic [7:0]   idx;
        logic         typed;
        t_rank_result want;
    } t_stim_row;

    localparam t_rank_result NO_WANT = '0;
    localparam int DIRECTED_ROWS = 22;

    // Rows with typed set carry a result that follows directly from the
    // table contents; the rest are left to the predictor.
    t_stim_row directed_rows [DIRECTED_ROWS] = '{
        '{FN_READ,   32'h0000_0000, 8'd0,   1'b1, '{ST_NOREAD, 9'd0, 32'h0, 9'd0}},
        '{FN_INSERT, 32'h0000_0000, 8'd0,   1'b1, '{ST_DONE,   9'd1, 32'h0, 9'd0}},
        '{FN_INSERT, 32'h7FFF_FFFF, 8'd0,   1'b1, '{ST_DONE,   9'd2, 32'h0, 9'd0}},
        '{FN_INSERT, 32'h8000_0000, 8'd0,   1'b1, '{ST_DONE,   9'd1, 32'h0, 9'd0}},
        '{FN_INSERT, 32'hFFFF_FFFF, 8'd0,   1'b0, NO_WANT},
        '{FN_INSERT, 32'h0000_0000, 8'd0,   1'b1, '{ST_DUP,    9'd0, 32'h0, 9'd0}},
        '{FN_INSERT, 32'h8000_0000, 8'hFF,  1'b1, '{ST_DUP,    9'd0, 32'h0, 9'd0}},
        '{FN_READ,   32'h0000_0000, 8'd0,   1'b0, NO_WANT},
        '{FN_READ,   32'h0000_0000, 8'd1,   1'b0, NO_WANT},
        '{FN_READ,   32'hFFFF_FFFF, 8'd2,   1'b0, NO_WANT},
        '{FN_READ,   32'h0000_0000, 8'd3,   1'b0, NO_WANT},
        '{FN_READ,   32'h0000_0000, 8'd4,   1'b1, '{ST_NOREAD, 9'd0, 32'h0, 9'd0}},
        '{FN_READ,   32'h0000_0000, 8'hFF,  1'b1, '{ST_NOREAD, 9'd0, 32'h0, 9'd0}},
        '{FN_UNUSED, 32'hFFFF_FFFF, 8'hFF,  1'b1, '{ST_DONE,   9'd0, 32'h0, 9'd0}},
        '{FN_CLEAR,  32'hA5A5_A5A5, 8'h5A,  1'b1, '{ST_DONE,   9'd0, 32'h0, 9'd0}},
        '{FN_READ,   32'h0000_0000, 8'd0,   1'b1, '{ST_NOREAD, 9'd0, 32'h0, 9'd0}},
        '{FN_INSERT, 32'h7FFF_FFFF, 8'd0,   1'b1, '{ST_DONE,   9'd1, 32'h0, 9'd0}},
        '{FN_INSERT, 32'h7FFF_FFFE, 8'd0,   1'b1, '{ST_DONE,   9'd1, 32'h0, 9'd0}},
        '{FN_READ,   32'h0000_0000, 8'd0,   1'b0, NO_WANT},
        '{FN_CLEAR,  32'h0000_0000, 8'd0,   1'b1, '{ST_DONE,   9'd0, 32'h0, 9'd0}},
        '{FN_INSERT, 32'h8000_0000, 8'd0,   1'b1, '{ST_DONE,   9'd1, 32'h0, 9'd0}},
        '{FN_READ,   32'h0000_0000, 8'd0,   1'b1,
          '{ST_DONE, 9'd0, 32'h8000_0000, 9'd1}}
    };

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_valid;
    logic [39:0] s_data;   // [31:0] new_value, [39:32] read_index
    logic [1:0]  s_user;   // [1:0] func
    logic        m_ready;
    wire         s_ready;
    wire         m_valid;
    wire  [55:0] m_data;   // [8:0] new_rank, [40:9] read_value, [49:41] read_rank
    wire  [1:0]  m_user;   // [1:0] status

    // Behavioral copy of the table.
    logic signed [31:0] tbl_value [RTDC_CAPACITY];
    logic [8:0]         tbl_rank  [RTDC_CAPACITY];
    int                 tbl_count;

    t_rank_result pending_results [$];
    int           err_count;
    int           cycle_count;
    int           send_idle_pct;
    int           recv_idle_pct;
    logic         long_stall_req;
    logic         long_stall_done;

    rank_table_with_duplicate_check_core dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_valid),
        .o_s_tready (s_ready),
        .i_s_tdata  (s_data),
        .i_s_tuser  (s_user),
        .o_m_tvalid (m_valid),
        .i_m_tready (m_ready),
        .o_m_tdata  (m_data),
        .o_m_tuser  (m_user)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[rank_table_with_duplicate_check_core] ERROR");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (err_count < MAX_REPORTS)
            $display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
        err_count++;
    endtask

    // Applies one command word to the table copy and returns its answer.
    function automatic t_rank_result rank_predict(input logic [1:0] fn,
                                                  input logic signed [31:0] val,
                                                  input logic [7:0] idx);
        t_rank_result res;
        int           below;
        logic         seen;
        res   = '0;
        below = 0;
        seen  = 1'b0;
        case (fn)
            FN_INSERT: begin
                for (int i = 0; i < tbl_count; i++) begin
                    if (tbl_value[i] == val)
                        seen = 1'b1;
                    else if (tbl_value[i] < val)
                        below++;
                end
                if (seen) begin
                    res.status = ST_DUP;
                end else if (tbl_count >= RTDC_CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    for (int i = 0; i < tbl_count; i++)
                        if (tbl_value[i] > val)
                            tbl_rank[i] = tbl_rank[i] + 9'd1;
                    tbl_value[tbl_count] = val;
                    tbl_rank[tbl_count]  = 9'(below + 1);
                    tbl_count++;
                    res.new_rank = 9'(below + 1);
                end
            end
            FN_READ: begin
                if (int'(idx) < tbl_count) begin
                    res.read_value = tbl_value[idx];
                    res.read_rank  = tbl_rank[idx];
                end else begin
                    res.status = ST_NOREAD;
                end
            end
            FN_CLEAR: tbl_count = 0;
            default: ;
        endcase
        return res;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_word(input logic [1:0] fn, input logic [31:0] val,
                             input logic [7:0] idx, input t_rank_result want);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge clk);
        end
        s_valid <= 1'b1;
        s_user  <= fn;
        s_data  <= {idx, val};
        do
            @(posedge clk);
        while (!s_ready);
        pending_results.push_back(want);
        @(negedge clk);
    endtask

    task automatic random_word(input int insert_pct, input int clear_pct);
        int unsigned pick;
        logic [1:0]  fn;
        logic [31:0] val;
        logic [7:0]  idx;
        pick = $urandom_range(0, 99);
        val  = $urandom;
        idx  = 8'($urandom_range(0, 255));
        if (pick < insert_pct) begin
            fn = FN_INSERT;
            // Reuse stored values and small numbers so duplicates are common.
            case ($urandom_range(0, 9))
                0, 1: if (tbl_count > 0)
                    val = tbl_value[$urandom_range(0, tbl_count - 1)];
                2: val = $urandom_range(0, 31) - 16;
                3: begin
                    case ($urandom_range(0, 3))
                        0: val = VAL_MIN;
                        1: val = VAL_MAX;
                        2: val = '0;
                        default: val = '1;
                    endcase
                end
                default: ;
            endcase
        end else if (pick >= 98) begin
            fn = FN_UNUSED;
        end else if (pick >= 98 - clear_pct) begin
            fn = FN_CLEAR;
        end else begin
            fn = FN_READ;
            if (tbl_count > 0 && $urandom_range(0, 4) != 0)
                idx = 8'($urandom_range(0, tbl_count - 1));
        end
        send_word(fn, val, idx, rank_predict(fn, val, idx));
    endtask

    // Receiver: random back pressure, plus one long hold-off on request.
    initial begin
        m_ready = 1'b0;
        long_stall_done = 1'b0;
        forever begin
            @(negedge clk);
            if (long_stall_req && !long_stall_done) begin
                long_stall_done = 1'b1;
                m_ready <= 1'b0;
                for (int n = 0; n < LONG_STALL_CYCLES; n++)
                    @(negedge clk);
            end else begin
                m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge clk) begin
        t_rank_result want;
        if (rst_n && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", 64'(m_data), 64'(m_user));
            end else begin
                want = pending_results.pop_front();
                if (m_user != want.status)
                    report_mismatch("status", 64'(m_user), 64'(want.status));
                if (m_data[8:0] != want.new_rank)
                    report_mismatch("new_rank", 64'(m_data[8:0]), 64'(want.new_rank));
                if (m_data[40:9] != want.read_value)
                    report_mismatch("read_value", 64'(m_data[40:9]),
                                    64'(want.read_value));
                if (m_data[49:41] != want.read_rank)
                    report_mismatch("read_rank", 64'(m_data[49:41]),
                                    64'(want.read_rank));
                if (m_data[55:50] != '0)
                    report_mismatch("tdata padding", 64'(m_data[55:50]), 64'd0);
            end
        end
    end

    initial begin
        t_rank_result want;
        rst_n          = 1'b0;
        s_valid        = 1'b0;
        s_data         = '0;
        s_user         = FN_INSERT;
        long_stall_req = 1'b0;
        send_idle_pct  = 19;
        recv_idle_pct  = 61;
        tbl_count      = 0;
        err_count      = 0;
        cycle_count    = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            want = rank_predict(directed_rows[r].fn, directed_rows[r].val,
                                directed_rows[r].idx);
            if (directed_rows[r].typed)
                want = directed_rows[r].want;
            send_word(directed_rows[r].fn, directed_rows[r].val,
                      directed_rows[r].idx, want);
        end

        repeat (240) random_word(55, 2);

        send_idle_pct = 61;
        recv_idle_pct = 19;
        repeat (240) random_word(55, 2);

        // Start from an empty table, hold the receiver off so the core backs
        // up, then fill to capacity and keep inserting into the full table.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_word(FN_CLEAR, '0, '0, rank_predict(FN_CLEAR, '0, '0));
        long_stall_req = 1'b1;
        while (tbl_count < RTDC_CAPACITY)
            random_word(85, 0);
        repeat (40) random_word(60, 0);
        s_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
            report_mismatch("missing results", 64'(pending_results.size()), 64'd0);

        if (err_count == 0)
            $display("[rank_table_with_duplicate_check_core] OK");
        else
            $display("[rank_table_with_duplicate_check_core] ERROR");
        $finish;
    end

endmodule
